// ===== rtl/ifm_pkg.sv =====
// Shared types and constants for the inverter fault monitor.
`timescale 1ns / 1ps
`default_nettype none

package ifm_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    ACT_CHECK = 2'd0,
    ACT_DESAT = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // Fault codes
  localparam logic [2:0] FAULT_NONE   = 3'd0;
  localparam logic [2:0] FAULT_RELAY  = 3'd1;
  localparam logic [2:0] FAULT_OVERV  = 3'd2;
  localparam logic [2:0] FAULT_UNDERV = 3'd3;
  localparam logic [2:0] FAULT_OVERC  = 3'd4;
  localparam logic [2:0] FAULT_OVERT  = 3'd5;
  localparam logic [2:0] FAULT_DESAT  = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] REG_MAX_BUS_V   = 3'd0;
  localparam logic [2:0] REG_MIN_BUS_V   = 3'd1;
  localparam logic [2:0] REG_CUR_LIMIT   = 3'd2;
  localparam logic [2:0] REG_MAX_TEMP    = 3'd3;
  localparam logic [2:0] REG_COOL_ON     = 3'd4;
  localparam logic [2:0] REG_COOL_OFF    = 3'd5;
  localparam logic [2:0] REG_DROP_GAIN   = 3'd6;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 12;

  typedef struct packed {
    logic [11:0] max_bus_voltage;
    logic [11:0] min_bus_voltage;
    logic [10:0] current_limit;
    logic [7:0]  max_temperature;
    logic [7:0]  cooling_on_temp;
    logic [7:0]  cooling_off_temp;
    logic [7:0]  drop_gain;
  } cfg_t;

  // Result of the limit tests for one check request
  typedef struct packed {
    logic [2:0] code;
    logic       relay_error;
    logic       cool_set;
    logic       cool_clr;
  } check_t;

endpackage

`default_nettype wire

// ===== rtl/ifm_cfg_regs.sv =====
// Configuration register file of the inverter fault monitor.
`timescale 1ns / 1ps
`default_nettype none

module ifm_cfg_regs import ifm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [CfgIndexWidth-1:0] wr_index,
  input  wire logic [CfgDataWidth-1:0]  wr_data,
  output cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_bus_voltage  <= 12'd400;
      cfg.min_bus_voltage  <= 12'd200;
      cfg.current_limit    <= 11'd500;
      cfg.max_temperature  <= 8'd110;
      cfg.cooling_on_temp  <= 8'd95;
      cfg.cooling_off_temp <= 8'd90;
      cfg.drop_gain        <= 8'd31;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAX_BUS_V: cfg.max_bus_voltage  <= wr_data;
        REG_MIN_BUS_V: cfg.min_bus_voltage  <= wr_data;
        REG_CUR_LIMIT: cfg.current_limit    <= wr_data[10:0];
        REG_MAX_TEMP:  cfg.max_temperature  <= wr_data[7:0];
        REG_COOL_ON:   cfg.cooling_on_temp  <= wr_data[7:0];
        REG_COOL_OFF:  cfg.cooling_off_temp <= wr_data[7:0];
        REG_DROP_GAIN: cfg.drop_gain        <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ifm_check.sv =====
// Limit tests and cooling hysteresis decision for one check request.
`timescale 1ns / 1ps
`default_nettype none

module ifm_check import ifm_pkg::*; (
  input  cfg_t               cfg,
  input  wire logic          running,
  input  wire logic          precharge_on,
  input  wire logic [11:0]   bus_voltage,
  input  wire logic signed [11:0] bus_current,
  input  wire logic signed [8:0]  temperature,
  output check_t             result
);

  logic signed [20:0] drop;
  logic signed [21:0] comp_v;
  logic signed [21:0] min_v;
  logic               over_v;
  logic               under_v;
  logic               over_c;
  logic               over_t;
  logic [2:0]         code;

  // voltage*256 + current*gain < min*256, exact
  assign drop    = 21'(bus_current) * 21'($signed({1'b0, cfg.drop_gain}));
  assign comp_v  = $signed({2'b00, bus_voltage, 8'h00}) + 22'(drop);
  assign min_v   = $signed({2'b00, cfg.min_bus_voltage, 8'h00});
  assign under_v = comp_v < min_v;
  assign over_v  = bus_voltage > cfg.max_bus_voltage;
  assign over_c  = bus_current > $signed({1'b0, cfg.current_limit});
  assign over_t  = temperature > $signed({1'b0, cfg.max_temperature});

  // later tests take priority
  always_comb begin
    code = FAULT_NONE;
    if (running) begin
      if (precharge_on) code = FAULT_RELAY;
      if (over_v)       code = FAULT_OVERV;
      if (under_v)      code = FAULT_UNDERV;
      if (over_c)       code = FAULT_OVERC;
      if (over_t)       code = FAULT_OVERT;
    end
  end

  assign result.code        = code;
  assign result.relay_error = running & precharge_on;
  assign result.cool_set    = temperature > $signed({1'b0, cfg.cooling_on_temp});
  assign result.cool_clr    = temperature < $signed({1'b0, cfg.cooling_off_temp});

endmodule

`default_nettype wire

// ===== rtl/inverter_fault_monitor.sv =====
// Top level of the inverter fault monitor: request pipeline and fault state.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per transfer:
//   a periodic check, a desaturation event or a fault reset. A request is
//   taken at a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   request, in order: stored fault code, fault_active, shutdown,
//   relay_error, cooling state and LED state after that request.
//   Config channel (cfg_valid / cfg_ready) writes one limit register per
//   transfer; cfg_ready is always high. Write only while no request is
//   in flight. Unknown indexes are ignored.
// Timing:
//   A request is captured in the input register, evaluated by a single
//   compare/multiply-add stage and written to the result register. One
//   request per cycle sustained while the receiver does not stall; the
//   fault, cooling and LED state update as a request enters the result reg.
// Reset: clears the pipeline, the fault code, cooling and LED, and loads
//   the default limits. When the receiver stalls, the result holds and the
//   input register fills, then in_stall rises until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module inverter_fault_monitor import ifm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // request channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               action,
  input  wire logic                     latch_update,
  input  wire logic                     running,
  input  wire logic                     precharge_on,
  input  wire logic [11:0]              bus_voltage,
  input  wire logic signed [11:0]       bus_current,
  input  wire logic signed [8:0]        temperature,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    fault_code,
  output logic                          fault_active,
  output logic                          shutdown,
  output logic                          relay_error,
  output logic                          cooling_on,
  output logic                          led_on,
  // configuration channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t   cfg;
  check_t chk;

  // input register
  logic              s1_valid;
  logic [1:0]        s1_action;
  logic              s1_latch;
  logic              s1_running;
  logic              s1_precharge;
  logic [11:0]       s1_voltage;
  logic signed [11:0] s1_current;
  logic signed [8:0]  s1_temp;

  // architectural state
  logic [2:0] stored_fault, stored_fault_next;
  logic       cooling_state, cooling_state_next;
  logic       led_state, led_state_next;
  logic       shutdown_next;
  logic       relay_error_next;

  logic advance;

  assign cfg_ready = 1'b1;

  ifm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ifm_check u_check (
    .cfg          (cfg),
    .running      (s1_running),
    .precharge_on (s1_precharge),
    .bus_voltage  (s1_voltage),
    .bus_current  (s1_current),
    .temperature  (s1_temp),
    .result       (chk)
  );

  // move stage 1 into the result register when it is free or draining
  assign advance  = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_action    <= action;
      s1_latch     <= latch_update;
      s1_running   <= running;
      s1_precharge <= precharge_on;
      s1_voltage   <= bus_voltage;
      s1_current   <= bus_current;
      s1_temp      <= temperature;
    end
  end

  always_comb begin
    stored_fault_next  = stored_fault;
    cooling_state_next = cooling_state;
    led_state_next     = led_state;
    shutdown_next      = 1'b0;
    relay_error_next   = 1'b0;
    case (action_t'(s1_action))
      ACT_CHECK: begin
        relay_error_next = chk.relay_error;
        if (chk.cool_set) cooling_state_next = 1'b1;
        if (chk.cool_clr) cooling_state_next = 1'b0;
        if (s1_latch) stored_fault_next = chk.code;
        if (stored_fault_next != FAULT_NONE) begin
          shutdown_next  = 1'b1;
          led_state_next = 1'b1;
        end
      end
      ACT_DESAT: begin
        stored_fault_next = FAULT_DESAT;
        led_state_next    = 1'b1;
        shutdown_next     = 1'b1;
      end
      ACT_CLEAR: begin
        stored_fault_next = FAULT_NONE;
        led_state_next    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_fault  <= FAULT_NONE;
      cooling_state <= 1'b0;
      led_state     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        stored_fault  <= stored_fault_next;
        cooling_state <= cooling_state_next;
        led_state     <= led_state_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (advance) begin
      fault_code   <= stored_fault_next;
      fault_active <= stored_fault_next != FAULT_NONE;
      shutdown     <= shutdown_next;
      relay_error  <= relay_error_next;
      cooling_on   <= cooling_state_next;
      led_on       <= led_state_next;
    end
  end

  // a stored fault always has the LED lit
  a_led_with_fault: assert property (@(posedge clk) disable iff (rst)
    stored_fault != FAULT_NONE |-> led_state)
    else $error("stored fault without LED");

  // state does not move while the result is held
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(stored_fault) && $stable(led_state))
    else $error("state changed under output stall");

  // input only stalls with a full pipeline
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with free stage");

  // result register mirrors the state it was written with
  a_out_tracks: assert property (@(posedge clk) disable iff (rst)
    advance |=> fault_code == stored_fault && led_on == led_state)
    else $error("result does not match state");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the inverter fault monitor.
`timescale 1ns / 1ps

module testbench;
  import ifm_pkg::*;

  // Codes the package leaves out: the spare opcode and the spare register slot.
  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam logic [2:0] REG_UNUSED  = 3'd7;

  // Two-stage pipe in the block; a little margin on top.
  localparam int SETTLE_CYCLES = 6;
  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int HANG_LIMIT = 2000;

  localparam cfg_t RESET_LIMITS = '{
    max_bus_voltage:  12'd400,
    min_bus_voltage:  12'd200,
    current_limit:    11'd500,
    max_temperature:  8'd110,
    cooling_on_temp:  8'd95,
    cooling_off_temp: 8'd90,
    drop_gain:        8'd31
  };

  typedef struct {
    logic [1:0]         act;
    logic               latch;
    logic               run;
    logic               pre;
    logic [11:0]        volt;
    logic signed [11:0] cur;
    logic signed [8:0]  temp;
  } request_t;

  typedef struct {
    logic [2:0] fault_code;
    logic       fault_active;
    logic       shutdown;
    logic       relay_error;
    logic       cooling_on;
    logic       led_on;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [1:0]               action       = ACT_CHECK;
  logic                     latch_update = 1'b0;
  logic                     running      = 1'b0;
  logic                     precharge_on = 1'b0;
  logic [11:0]              bus_voltage  = '0;
  logic signed [11:0]       bus_current  = '0;
  logic signed [8:0]        temperature  = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic [2:0]               fault_code;
  logic                     fault_active;
  logic                     shutdown;
  logic                     relay_error;
  logic                     cooling_on;
  logic                     led_on;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index    = '0;
  logic [CfgDataWidth-1:0]  cfg_data     = '0;

  inverter_fault_monitor i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .latch_update (latch_update),
    .running      (running),
    .precharge_on (precharge_on),
    .bus_voltage  (bus_voltage),
    .bus_current  (bus_current),
    .temperature  (temperature),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fault_code   (fault_code),
    .fault_active (fault_active),
    .shutdown     (shutdown),
    .relay_error  (relay_error),
    .cooling_on   (cooling_on),
    .led_on       (led_on),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: limits as the block should hold them, plus the latched
  // fault code, cooling hysteresis state and LED.
  // ---------------------------------------------------------------------------
  cfg_t       limits_now  = RESET_LIMITS;
  logic [2:0] fault_now   = FAULT_NONE;
  logic       cooling_now = 1'b0;
  logic       led_now     = 1'b0;

  status_t pending_status[$];
  int      mismatches     = 0;
  bit      steady_traffic = 1'b0;   // when set, neither side inserts gaps
  int      idle_cycles    = 0;

  // Register writes truncate to the register's width.
  function automatic void apply_register(logic [2:0] idx, logic [11:0] data);
    case (idx)
      REG_MAX_BUS_V: limits_now.max_bus_voltage  = data;
      REG_MIN_BUS_V: limits_now.min_bus_voltage  = data;
      REG_CUR_LIMIT: limits_now.current_limit    = data[10:0];
      REG_MAX_TEMP:  limits_now.max_temperature  = data[7:0];
      REG_COOL_ON:   limits_now.cooling_on_temp  = data[7:0];
      REG_COOL_OFF:  limits_now.cooling_off_temp = data[7:0];
      REG_DROP_GAIN: limits_now.drop_gain        = data[7:0];
      default: ;
    endcase
  endfunction

  // Expected status after one request; advances the predictor state.
  function automatic status_t predict_status(request_t rq);
    status_t    res;
    logic [2:0] code;
    int         v, c, t;
    v = int'(rq.volt);
    c = int'(rq.cur);
    t = int'(rq.temp);
    res.shutdown    = 1'b0;
    res.relay_error = 1'b0;
    case (rq.act)
      ACT_CHECK: begin
        // Tests run in priority order; the last one to trip wins.
        code = FAULT_NONE;
        if (rq.run) begin
          if (rq.pre) begin
            res.relay_error = 1'b1;
            code = FAULT_RELAY;
          end
          if (v > int'(limits_now.max_bus_voltage))
            code = FAULT_OVERV;
          // Bus sag compensated by I * gain (Q0.8), compared exactly.
          if (v * 256 + c * int'(limits_now.drop_gain) <
              int'(limits_now.min_bus_voltage) * 256)
            code = FAULT_UNDERV;
          if (c > int'(limits_now.current_limit))
            code = FAULT_OVERC;
          if (t > int'(limits_now.max_temperature))
            code = FAULT_OVERT;
        end
        // Hysteresis; with crossed thresholds the off test wins.
        if (t > int'(limits_now.cooling_on_temp))
          cooling_now = 1'b1;
        if (t < int'(limits_now.cooling_off_temp))
          cooling_now = 1'b0;
        if (rq.latch)
          fault_now = code;
        // Clearing via check does not turn the LED off.
        if (fault_now != FAULT_NONE) begin
          res.shutdown = 1'b1;
          led_now = 1'b1;
        end
      end
      ACT_DESAT: begin
        fault_now    = FAULT_DESAT;
        led_now      = 1'b1;
        res.shutdown = 1'b1;
      end
      ACT_CLEAR: begin
        fault_now = FAULT_NONE;
        led_now   = 1'b0;
      end
      default: ;
    endcase
    res.fault_code   = fault_now;
    res.fault_active = (fault_now != FAULT_NONE);
    res.cooling_on   = cooling_now;
    res.led_on       = led_now;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly back-to-back, some short gaps, a rare long one.
  function automatic int gap_len();
    int pick;
    if (steady_traffic)
      return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      return 0;
    if (pick < 88)
      return $urandom_range(1, 3);
    if (pick < 97)
      return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic request_t check_req(bit latch, bit run, bit pre,
                                         int volt, int cur, int temp);
    request_t rq;
    rq.act   = ACT_CHECK;
    rq.latch = latch;
    rq.run   = run;
    rq.pre   = pre;
    rq.volt  = 12'(volt);
    rq.cur   = 12'(cur);
    rq.temp  = 9'(temp);
    return rq;
  endfunction

  // Non-check request; payload is don't-care, so scramble it.
  function automatic request_t event_req(logic [1:0] act);
    request_t rq;
    rq = check_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)),
                   $urandom_range(0, 4095), $urandom_range(0, 4095) - 2048,
                   $urandom_range(0, 319) - 64);
    rq.act = act;
    return rq;
  endfunction

  // Random request steered toward the current thresholds so every test,
  // the priority override and the cooling hysteresis get exercised.
  function automatic request_t random_request();
    request_t rq;
    int pick, volt, cur, temp;
    pick = $urandom_range(0, 99);
    if (pick < 82)
      rq.act = ACT_CHECK;
    else if (pick < 89)
      rq.act = ACT_DESAT;
    else if (pick < 96)
      rq.act = ACT_CLEAR;
    else
      rq.act = ACT_IGNORED;
    rq.latch = ($urandom_range(0, 3) != 0);
    rq.run   = ($urandom_range(0, 4) != 0);
    rq.pre   = ($urandom_range(0, 4) == 0);

    case ($urandom_range(0, 2))
      0: cur = $urandom_range(0, 4095) - 2048;
      1: cur = int'(limits_now.current_limit) + $urandom_range(0, 8) - 4;
      default: cur = $urandom_range(0, 400) - 200;
    endcase
    cur = clamp(cur, -2048, 2047);

    case ($urandom_range(0, 3))
      0: volt = $urandom_range(0, 4095);
      1: volt = int'(limits_now.max_bus_voltage) + $urandom_range(0, 8) - 4;
      // Right at the compensated undervoltage edge.
      2: volt = int'(limits_now.min_bus_voltage)
                - (cur * int'(limits_now.drop_gain)) / 256
                + int'($urandom_range(0, 4)) - 2;
      default: volt = int'(limits_now.min_bus_voltage) + $urandom_range(0, 32) - 16;
    endcase
    volt = clamp(volt, 0, 4095);

    case ($urandom_range(0, 3))
      0: temp = $urandom_range(0, 319) - 64;
      1: temp = int'(limits_now.max_temperature) + $urandom_range(0, 6) - 3;
      2: temp = int'(limits_now.cooling_on_temp) + $urandom_range(0, 6) - 3;
      default: temp = int'(limits_now.cooling_off_temp) + $urandom_range(0, 6) - 3;
    endcase
    temp = clamp(temp, -64, 255);

    rq.volt = 12'(volt);
    rq.cur  = 12'(cur);
    rq.temp = 9'(temp);
    return rq;
  endfunction

  function automatic cfg_t random_limits();
    cfg_t lim;
    lim.max_bus_voltage  = 12'($urandom_range(250, 700));
    lim.min_bus_voltage  = 12'($urandom_range(80, 300));
    lim.current_limit    = 11'($urandom_range(100, 1800));
    lim.max_temperature  = 8'($urandom_range(70, 200));
    lim.cooling_on_temp  = 8'($urandom_range(40, 120));
    lim.cooling_off_temp = lim.cooling_on_temp - 8'($urandom_range(0, 10));
    lim.drop_gain        = 8'($urandom_range(0, 255));
    return lim;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------
  // Presents one request and returns in the step it is taken. in_valid is
  // left high so a following request can go back-to-back; whoever comes next
  // (another send or settle) drops it or keeps it high in this same step.
  task automatic send_request(input request_t rq);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= rq.act;
    latch_update <= rq.latch;
    running      <= rq.run;
    precharge_on <= rq.pre;
    bus_voltage  <= rq.volt;
    bus_current  <= rq.cur;
    temperature  <= rq.temp;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_status.push_back(predict_status(rq));
  endtask

  // Writes every register back-to-back, then the spare slot, which must be
  // ignored. Bits above a register's width carry junk to check truncation.
  task automatic program_limits(input cfg_t lim);
    logic [2:0]  idx;
    logic [11:0] val, mask, junk;
    for (int r = 0; r <= int'(REG_UNUSED); r++) begin
      idx = r[2:0];
      case (idx)
        REG_MAX_BUS_V: begin val = lim.max_bus_voltage;         mask = 12'hFFF; end
        REG_MIN_BUS_V: begin val = lim.min_bus_voltage;         mask = 12'hFFF; end
        REG_CUR_LIMIT: begin val = {1'b0, lim.current_limit};   mask = 12'h7FF; end
        REG_MAX_TEMP:  begin val = {4'h0, lim.max_temperature}; mask = 12'h0FF; end
        REG_COOL_ON:   begin val = {4'h0, lim.cooling_on_temp}; mask = 12'h0FF; end
        REG_COOL_OFF:  begin val = {4'h0, lim.cooling_off_temp}; mask = 12'h0FF; end
        REG_DROP_GAIN: begin val = {4'h0, lim.drop_gain};       mask = 12'h0FF; end
        default:       begin val = 12'($urandom);               mask = 12'hFFF; end
      endcase
      junk = 12'($urandom);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= (junk & ~mask) | (val & mask);
      do @(posedge clk); while (cfg_ready !== 1'b1);
      apply_register(idx, (junk & ~mask) | (val & mask));
    end
    cfg_valid <= 1'b0;
  endtask

  // Drain: stop sending, wait for every expected status, then let the pipe
  // empty out. Needed before any register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random receiver back-pressure.
  initial begin
    int hold;
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      hold = gap_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected status, expected none, actual fault_code %0d",
                 $time, fault_code);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("fault_code",   want.fault_code,   fault_code);
        check_field("fault_active", want.fault_active, fault_active);
        check_field("shutdown",     want.shutdown,     shutdown);
        check_field("relay_error",  want.relay_error,  relay_error);
        check_field("cooling_on",   want.cooling_on,   cooling_on);
        check_field("led_on",       want.led_on,       led_on);
      end
    end
  end

  // Hang detector: resets on any transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == HANG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset limits: field extremes, each fault, priority, latch semantics,
  // events, the spare opcode and the cooling hysteresis edges.
  task automatic test_directed_checks();
    send_request(check_req(1, 0, 1, 4095, 2047, 255));  // idle drive: no tests
    send_request(check_req(1, 1, 1, 300, 0, 25));       // relay stuck on
    send_request(check_req(1, 1, 1, 4095, 0, 25));      // overvolt beats relay
    send_request(check_req(1, 1, 0, 0, 0, 25));         // plain undervolt
    send_request(check_req(1, 1, 0, 300, -2048, 25));   // sag from regen current
    send_request(check_req(1, 1, 0, 180, 2047, 25));    // lifted above, overcurrent
    send_request(check_req(1, 1, 1, 0, 2047, 255));     // relay, overcurrent, overtemp trip
    send_request(check_req(0, 1, 0, 0, 0, 25));         // no latch: code kept
    send_request(check_req(1, 1, 0, 300, 0, 92));       // latch clears, LED stays
    send_request(event_req(ACT_CLEAR));
    send_request(check_req(1, 1, 0, 400, 500, 110));    // exactly on limits
    send_request(check_req(1, 1, 0, 401, 0, 96));       // one over; cooling on
    send_request(check_req(1, 1, 0, 300, 0, 90));       // at off temp: holds
    send_request(check_req(1, 1, 0, 300, 0, -64));      // coldest: cooling off
    send_request(event_req(ACT_DESAT));
    send_request(check_req(0, 0, 0, 300, 0, 25));       // desat code held
    send_request(event_req(ACT_IGNORED));
    send_request(event_req(ACT_CLEAR));
    settle();
  endtask

  // Limits at zero, at all ones, and with crossed cooling thresholds.
  task automatic test_register_extremes();
    cfg_t crossed;
    crossed = RESET_LIMITS;
    crossed.cooling_on_temp  = 8'd60;
    crossed.cooling_off_temp = 8'd100;
    program_limits('0);
    repeat (6) send_request(random_request());
    settle();
    program_limits('1);
    repeat (6) send_request(random_request());
    settle();
    program_limits(crossed);
    send_request(check_req(1, 1, 0, 300, 0, 80));   // both hold: off wins
    repeat (5) send_request(random_request());
    settle();
  endtask

  // Random traffic over several random limit sets; one phase runs with no
  // gaps on either side.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      program_limits(random_limits());
      steady_traffic = (phase == 2);
      repeat (75) send_request(random_request());
      settle();
    end
    steady_traffic = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_checks();
    test_register_extremes();
    test_random_traffic();
    settle();
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
